@@ rtl/max_pool_2d_argmax_macros.svh @@
// -----------------------------------------------------------------------------
// max_pool_2d_argmax_macros
// Assertion macros used by the checker file.
// -----------------------------------------------------------------------------
`ifndef MAX_POOL_2D_ARGMAX_MACROS_SVH
`define MAX_POOL_2D_ARGMAX_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define MP_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("mp assertion failed");
// Next-cycle implication checked outside reset.
`define MP_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("mp assertion failed");
`endif

@@ rtl/mp2d_pkg.sv @@
// -----------------------------------------------------------------------------
// mp2d_pkg
// Register indexes and the shared job type for the max pooling block.
// -----------------------------------------------------------------------------
`default_nettype none
package mp2d_pkg;
  localparam int CfgBits = 9;
  localparam int CfgIdxBits = 3;
  localparam logic [CfgIdxBits-1:0] REG_KERNEL = 3'd0;
  localparam logic [CfgIdxBits-1:0] REG_STRIDE = 3'd1;
  localparam logic [CfgIdxBits-1:0] REG_WIDTH  = 3'd2;
  localparam logic [CfgIdxBits-1:0] REG_HEIGHT = 3'd3;

  // Window job handed from the front end to the scan unit.
  typedef struct packed {
    logic [11:0] y0;
    logic [11:0] x0;
    logic [11:0] oy;
    logic [11:0] ox;
    logic        last;
    logic [9:0]  chan;
  } mp2d_job_t;
endpackage
`default_nettype wire

@@ rtl/mp2d_stream_if.sv @@
// -----------------------------------------------------------------------------
// mp2d_stream_if
// Valid/ready channel carrying a generic payload.
// -----------------------------------------------------------------------------
`default_nettype none
interface mp2d_stream_if #(parameter int W = 16);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/mp2d_scan.sv @@
// -----------------------------------------------------------------------------
// mp2d_scan
// Line memory and the window scan: one stored pixel read per cycle.
// -----------------------------------------------------------------------------
`default_nettype none
module mp2d_scan import mp2d_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_KERNEL = 4,
  parameter int VALUE_BITS = 16,
  parameter int KB = 3
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  wr_en,
  input  wire logic [11:0]           wr_row,
  input  wire logic [11:0]           wr_col,
  input  wire logic [VALUE_BITS-1:0] wr_data,
  input  wire logic                  job_valid,
  input  wire mp2d_job_t             job,
  input  wire logic [KB-1:0]         k,
  output logic                       busy,
  output logic                       done,
  output logic [VALUE_BITS-1:0]      best,
  output logic [11:0]                best_row,
  output logic [11:0]                best_col
);
  localparam int RB = (MAX_KERNEL > 1) ? $clog2(MAX_KERNEL) : 1;
  localparam int CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int AB = RB + CB;
  localparam int DEPTH = 1 << AB;

  logic [VALUE_BITS-1:0] mem [DEPTH];
  logic [VALUE_BITS-1:0] rd_data;
  logic [KB-1:0] dx, dy;
  logic          rd_pend, first;
  logic [11:0]   pend_row, pend_col, ry, rx;
  logic          scanning, last_rd, pend_last;

  // Slot address: low row bits pick the line, low column bits the entry.
  // The line count is a power of two no smaller than the kernel, so the
  // rows of one window never share a line.
  function automatic logic [AB-1:0] slot_of(input logic [11:0] r, input logic [11:0] c);
    return {r[RB-1:0], c[CB-1:0]};
  endfunction

  assign ry = job.y0 + 12'(dy);
  assign rx = job.x0 + 12'(dx);
  assign last_rd = (dx == k - KB'(1)) && (dy == k - KB'(1));

  // Memory write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) mem[slot_of(wr_row, wr_col)] <= wr_data;
    rd_data <= mem[slot_of(ry, rx)];
  end

  assign busy = scanning || rd_pend;

  // Column-major read sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      scanning <= 1'b0;
      rd_pend  <= 1'b0;
      done     <= 1'b0;
      dx <= '0;
      dy <= '0;
    end else begin
      done    <= rd_pend && pend_last;
      rd_pend <= scanning;
      if (!scanning && job_valid) begin
        scanning <= 1'b1;
        dx <= '0;
        dy <= '0;
      end else if (scanning) begin
        if (last_rd) scanning <= 1'b0;
        else if (dy == k - KB'(1)) begin
          dy <= '0;
          dx <= dx + KB'(1);
        end else dy <= dy + KB'(1);
      end
    end
  end

  // Running maximum; strictly greater replaces, so ties keep the first.
  always_ff @(posedge clk) begin
    pend_row  <= ry;
    pend_col  <= rx;
    pend_last <= last_rd;
    if (scanning) first <= (dx == '0) && (dy == '0);
    if (rd_pend && (first || $signed(rd_data) > $signed(best))) begin
      best     <= rd_data;
      best_row <= pend_row;
      best_col <= pend_col;
    end
  end
endmodule
`default_nettype wire

@@ rtl/max_pool_2d_argmax.sv @@
// -----------------------------------------------------------------------------
// max_pool_2d_argmax
// Max pooling with argmax over raster-order planes.
// -----------------------------------------------------------------------------
// Channel   Dir  Payload
// pix       in   pixel_value (16b signed)
// res       out  pooled_value, source_row/col, out_row/col, channel, plane_last
// cfg       in   cfg_we, cfg_index, cfg_data
// A pixel that closes no window needs no scan. A closing pixel starts the
// window scan, which reads one line-memory entry per cycle.
// The result sits in an output register; the next pixel is taken while it waits,
// but a new window waits until the previous result has been taken.
// Reset is synchronous; the line memory needs no clearing.
`default_nettype none
module max_pool_2d_argmax import mp2d_pkg::*; #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int MAX_KERNEL   = 4,
  parameter int MAX_CHANNELS = 64,
  parameter int VALUE_BITS   = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CfgIdxBits-1:0] cfg_index,
  input  wire logic [CfgBits-1:0]   cfg_data,
  mp2d_stream_if.sink               pix,
  mp2d_stream_if.source             res
);
  localparam int KB = $clog2(MAX_KERNEL + 1);
  localparam int CHB = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  logic [2:0] kernel_size;
  logic [3:0] stride;
  logic [8:0] image_width, image_height;
  logic [11:0] col, row, oy_cnt, ox_cnt;
  logic [3:0]  sy, sx;
  logic [CHB-1:0] chan;
  logic [KB-1:0] k;
  logic [3:0] s;
  logic [11:0] w, h;
  logic hit, accept, job_valid, busy, done, out_full;
  mp2d_job_t job, job_reg;
  logic [VALUE_BITS-1:0] best;
  logic [11:0] best_row, best_col;

  // Effective register values.
  always_comb begin
    k = (kernel_size == 3'd0) ? KB'(1) :
        (32'(kernel_size) > MAX_KERNEL) ? KB'(MAX_KERNEL) : KB'(kernel_size);
    s = (stride == 4'd0) ? 4'd1 : stride;
    w = (image_width == 9'd0) ? 12'd1 :
        (32'(image_width) > MAX_WIDTH) ? 12'(MAX_WIDTH) : 12'(image_width);
    h = (image_height == 9'd0) ? 12'd1 :
        (32'(image_height) > MAX_HEIGHT) ? 12'(MAX_HEIGHT) : 12'(image_height);
  end

  // Window-phase counters replace the modulo: sy/sx count the stride phase
  // and oy/ox the pooled index.
  assign hit = (row + 12'd1 >= 12'(k)) && (col + 12'd1 >= 12'(k)) &&
               (sy == 4'd0) && (sx == 4'd0);
  assign accept = pix.valid && pix.ready;
  assign pix.ready = !busy && !job_valid &&
                     !(hit && (done || (out_full && !res.ready)));

  // A window is the last of its plane when the next origin one stride on
  // would no longer fit, both down and across.
  always_comb begin
    job.y0   = row + 12'd1 - 12'(k);
    job.x0   = col + 12'd1 - 12'(k);
    job.oy   = oy_cnt;
    job.ox   = ox_cnt;
    job.last = (row + 12'(s) >= h) && (col + 12'(s) >= w);
    job.chan = 10'(chan);
  end

  // Position, channel and configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_size <= 3'd2; stride <= 4'd2;
      image_width <= 9'd256; image_height <= 9'd256;
      col <= '0; row <= '0; chan <= '0; sy <= '0; sx <= '0;
      oy_cnt <= '0; ox_cnt <= '0; job_valid <= 1'b0;
    end else begin
      job_valid <= 1'b0;
      if (cfg_we && cfg_index <= REG_HEIGHT) begin
        case (cfg_index)
          REG_KERNEL: kernel_size <= cfg_data[2:0];
          REG_STRIDE: stride <= cfg_data[3:0];
          REG_WIDTH:  image_width <= cfg_data;
          REG_HEIGHT: image_height <= cfg_data;
          default: ;
        endcase
        col <= '0; row <= '0; sy <= '0; sx <= '0; oy_cnt <= '0; ox_cnt <= '0;
      end else if (accept) begin
        if (hit) begin
          job_valid <= 1'b1;
          job_reg <= job;
        end
        if (col + 12'd1 >= 12'(k))
          if (sx == s - 4'd1) begin
            sx <= '0;
            ox_cnt <= ox_cnt + 12'd1;
          end else sx <= sx + 4'd1;
        if (col + 12'd1 >= w) begin
          col <= '0; sx <= '0; ox_cnt <= '0;
          if (row + 12'd1 >= 12'(k))
            if (sy == s - 4'd1) begin sy <= '0; oy_cnt <= oy_cnt + 12'd1; end
            else sy <= sy + 4'd1;
          if (row + 12'd1 >= h) begin
            row <= '0; sy <= '0; oy_cnt <= '0;
            chan <= (32'(chan) == MAX_CHANNELS - 1) ? '0 : chan + CHB'(1);
          end else row <= row + 12'd1;
        end else col <= col + 12'd1;
      end
    end
  end

  mp2d_scan #(.MAX_WIDTH(MAX_WIDTH), .MAX_KERNEL(MAX_KERNEL), .VALUE_BITS(VALUE_BITS),
              .KB(KB)) u_scan (
    .clk, .rst,
    .wr_en(accept), .wr_row(row), .wr_col(col), .wr_data(pix.data[VALUE_BITS-1:0]),
    .job_valid, .job(job_reg), .k, .busy, .done,
    .best, .best_row, .best_col
  );

  // Output register.
  mp2d_job_t job_hold;
  always_ff @(posedge clk) begin
    if (job_valid) job_hold <= job_reg;
    if (rst) out_full <= 1'b0;
    else if (done) out_full <= 1'b1;
    else if (res.ready) out_full <= 1'b0;
    if (done) begin
      res.data <= {best, best_row[7:0], best_col[7:0], job_hold.oy[7:0], job_hold.ox[7:0],
                   job_hold.chan[5:0], job_hold.last};
    end
  end
  assign res.valid = out_full;
endmodule
`default_nettype wire

@@ rtl/mp2d_checker.sv @@
// -----------------------------------------------------------------------------
// mp2d_checker
// Port-level checks for the max pooling block.
// -----------------------------------------------------------------------------
`default_nettype none
`include "max_pool_2d_argmax_macros.svh"
module mp2d_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic cfg_we
);
  `MP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `MP_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !out_valid)
  `MP_ASSERT_IMPL(a_ready_known, clk, rst, 1'b1, in_ready == 1'b0 || in_ready == 1'b1)
  `MP_ASSERT_IMPL(a_cfg_idle, clk, rst, cfg_we, !(in_valid && in_ready))
endmodule
bind max_pool_2d_argmax mp2d_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(pix.valid), .in_ready(pix.ready),
  .out_valid(res.valid), .out_ready(res.ready), .cfg_we(cfg_we)
);
`default_nettype wire

@@ verif/max_pool_2d_argmax_test.sv @@
// -----------------------------------------------------------------------------
// max_pool_2d_argmax_test
// Self-checking bench for the max pooling block. Pixel planes are streamed in
// bursts under several register settings, and every pooled result is compared
// field by field with a behavioral prediction of the window maximum and argmax.
// -----------------------------------------------------------------------------
`default_nettype none
module max_pool_2d_argmax_test;
  import mp2d_pkg::*;

  localparam int LineDepth = 256;
  localparam int KernelMax = 4;
  localparam int ChanCount = 64;
  localparam int CycleLimit = 400000;
  localparam logic [CfgIdxBits-1:0] REG_UNUSED = 3'd5;

  typedef struct packed {
    logic signed [15:0] pooled_value;
    logic [7:0]         source_row;
    logic [7:0]         source_col;
    logic [7:0]         out_row;
    logic [7:0]         out_col;
    logic [5:0]         channel;
    logic               plane_last;
  } pool_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [CfgBits-1:0] cfg_data = '0;

  mp2d_stream_if #(.W(16)) pix ();
  mp2d_stream_if #(.W($bits(pool_result_t))) res ();

  max_pool_2d_argmax u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pix(pix), .res(res)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stimulus and prediction state.
  logic [15:0] pixel_queue[$];
  pool_result_t pooled_expect[$];
  logic [15:0] window_rows[0:KernelMax*LineDepth-1];
  logic [2:0] pk_kernel;
  logic [3:0] pk_stride;
  logic [8:0] pk_width, pk_height;
  int unsigned pk_row, pk_col, pk_chan;
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned sent = 0;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Predict the pooled result caused by one pixel transfer.
  task automatic pool_pixel(input logic [15:0] px);
    int unsigned k, s, w, h, y0, x0, by, bx, ly, lx;
    logic signed [15:0] best, v;
    pool_result_t r;
    k = clamp_size(pk_kernel, KernelMax);
    s = (pk_stride == 0) ? 1 : pk_stride;
    w = clamp_size(pk_width, LineDepth);
    h = clamp_size(pk_height, 256);
    window_rows[(pk_row % KernelMax) * LineDepth + pk_col] = px;
    if (pk_row + 1 >= k && pk_col + 1 >= k &&
        (pk_row + 1 - k) % s == 0 && (pk_col + 1 - k) % s == 0) begin
      y0 = pk_row + 1 - k;
      x0 = pk_col + 1 - k;
      by = y0;
      bx = x0;
      best = window_rows[(y0 % KernelMax) * LineDepth + x0];
      // Column-major scan with strict compare keeps the first maximum.
      for (int dx = 0; dx < k; dx++) begin
        for (int dy = 0; dy < k; dy++) begin
          v = window_rows[((y0 + dy) % KernelMax) * LineDepth + x0 + dx];
          if (v > best) begin
            best = v;
            by = y0 + dy;
            bx = x0 + dx;
          end
        end
      end
      ly = (h - k) / s;
      lx = (w - k) / s;
      r.pooled_value = best;
      r.source_row = by[7:0];
      r.source_col = bx[7:0];
      r.out_row = 8'(y0 / s);
      r.out_col = 8'(x0 / s);
      r.channel = pk_chan[5:0];
      r.plane_last = (y0 / s == ly) && (x0 / s == lx);
      pooled_expect.push_back(r);
    end
    // Raster position and channel stepping.
    if (pk_col + 1 >= w) begin
      pk_col = 0;
      if (pk_row + 1 >= h) begin
        pk_row = 0;
        pk_chan = (pk_chan + 1) % ChanCount;
      end else begin
        pk_row = pk_row + 1;
      end
    end else begin
      pk_col = pk_col + 1;
    end
  endtask

  // Track register writes and pixel transfers on the same edge as the block.
  always @(posedge clk) begin
    if (rst) begin
      pk_kernel <= 3'd2;
      pk_stride <= 4'd2;
      pk_width <= 9'd256;
      pk_height <= 9'd256;
      pk_row = 0;
      pk_col = 0;
      pk_chan = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KERNEL: pk_kernel <= cfg_data[2:0];
          REG_STRIDE: pk_stride <= cfg_data[3:0];
          REG_WIDTH:  pk_width <= cfg_data;
          REG_HEIGHT: pk_height <= cfg_data;
          default: ;
        endcase
        if (cfg_index <= REG_HEIGHT) begin
          pk_row = 0;
          pk_col = 0;
        end
      end
      if (pix.valid && pix.ready) pool_pixel(pix.data);
    end
  end

  // Pixel driver: random bursts and gaps, with a hold for draining.
  logic hold_pixels = 1'b1;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      pix.valid <= 1'b0;
      pix.data <= '0;
    end else if (!pix.valid || pix.ready) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        pix.valid <= 1'b0;
      end else if (!hold_pixels && pixel_queue.size() > 0) begin
        pix.valid <= 1'b1;
        pix.data <= pixel_queue.pop_front();
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        pix.valid <= 1'b0;
      end
    end
  end

  // Result monitor with its own stall pattern.
  int unsigned ready_mode = 0;
  int unsigned mode_left = 0;
  pool_result_t got, want;
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        ready_mode <= $urandom_range(0, 3);
        mode_left <= $urandom_range(20, 120);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (ready_mode)
        0: res.ready <= 1'b1;
        1: res.ready <= $urandom_range(0, 1);
        2: res.ready <= ($urandom_range(0, 7) == 0);
        default: res.ready <= (cycles % 5 != 0);
      endcase
      if (res.valid && res.ready) begin
        got = res.data;
        if (pooled_expect.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", got);
        end else begin
          want = pooled_expect.pop_front();
          if (got.pooled_value !== want.pooled_value || got.source_row !== want.source_row ||
              got.source_col !== want.source_col || got.out_row !== want.out_row ||
              got.out_col !== want.out_col || got.channel !== want.channel ||
              got.plane_last !== want.plane_last) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
          end
        end
      end
    end
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxBits-1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CfgBits-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_shape(input int unsigned k, s, w, h);
    write_reg(REG_KERNEL, k);
    write_reg(REG_STRIDE, s);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Release queued pixels and wait for every transfer and result to finish.
  task automatic run_and_drain();
    hold_pixels = 1'b0;
    while (pixel_queue.size() > 0 || pix.valid || pooled_expect.size() > 0)
      @(posedge clk);
    hold_pixels = 1'b1;
    // Let the block settle before the next register write.
    repeat (30) @(posedge clk);
  endtask

  // Queue pixels; style 0 random, 1 all equal, 2 extremes, 3 narrow range for ties.
  task automatic queue_pixels(input int unsigned count, input int unsigned style);
    logic [15:0] same;
    same = 16'($urandom);
    for (int i = 0; i < count; i++) begin
      case (style)
        0: pixel_queue.push_back(16'($urandom));
        1: pixel_queue.push_back(same);
        2: pixel_queue.push_back(($urandom_range(0, 1) == 1) ? 16'h7fff : 16'h8000);
        default: pixel_queue.push_back(16'($signed($urandom_range(0, 3)) - 2));
      endcase
    end
    sent += count;
  endtask

  int unsigned k, s, w, h, planes;
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: a partial first row gives no window yet.
    queue_pixels(12, 0);
    run_and_drain();

    // Directed: extremes, ties, zero and oversized registers.
    set_shape(2, 2, 4, 2);
    queue_pixels(8, 2);
    run_and_drain();
    queue_pixels(8, 1);
    run_and_drain();
    set_shape(0, 0, 0, 0);
    queue_pixels(3, 2);
    run_and_drain();
    set_shape(7, 15, 3, 2);
    queue_pixels(6, 0);
    run_and_drain();
    write_reg(REG_UNUSED, 9'h1ff);
    set_shape(4, 8, 300, 1);
    queue_pixels(256, 0);
    run_and_drain();
    set_shape(1, 9, 1, 260);
    queue_pixels(256, 3);
    run_and_drain();
    set_shape(1, 1, 1, 1);
    queue_pixels(66, 0);
    run_and_drain();

    // Random whole planes under random shapes, mostly valid settings.
    while (sent < 780) begin
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(1, 4);
      s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 4);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 14);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 9);
      set_shape(k, s, w, h);
      planes = $urandom_range(1, 3);
      for (int p = 0; p < planes; p++)
        if (p == 0 || sent < 780)
          queue_pixels(clamp_size(w, 256) * clamp_size(h, 256), $urandom_range(0, 3));
      // Sometimes cut the last plane short; the next write restarts position.
      if ($urandom_range(0, 3) == 0) queue_pixels($urandom_range(1, 10), 0);
      run_and_drain();
    end

    mismatches += pooled_expect.size();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
